>>> design/binary_min_heap_queue_core_defines.svh
// ---------------------------------------------------------------------------
// binary_min_heap_queue_core_defines.svh
// Assertion macros shared by the heap queue modules.
// ---------------------------------------------------------------------------
`ifndef BINARY_MIN_HEAP_QUEUE_CORE_DEFINES_SVH
`define BINARY_MIN_HEAP_QUEUE_CORE_DEFINES_SVH

// check a property on every clock outside reset
`define BMHQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check that a condition implies a consequence in the same cycle
`define BMHQ_ASSERT_IMP(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (cons)) \
    else $error(msg);

// check that a condition implies a consequence in the following cycle
`define BMHQ_ASSERT_NEXT(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (cons)) \
    else $error(msg);

`endif

>>> design/bmhq_pkg.sv
// ---------------------------------------------------------------------------
// bmhq_pkg
// Types, codes and constants of the binary min-heap queue.
// ---------------------------------------------------------------------------
package bmhq_pkg;

  localparam int DEFAULT_CAPACITY = 64;
  localparam int VALUE_W          = 32;
  localparam int COUNT_W          = 7;
  localparam int STATUS_W         = 2;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_PUSH_INIT,
    DP_POP_INIT,
    DP_RD_PARENT,
    DP_UP_STEP,
    DP_RD_LAST,
    DP_LOAD_MOV,
    DP_RD_KIDS,
    DP_DOWN_STEP,
    DP_WR_MOV,
    DP_REPORT
  } dp_cmd_e;

  typedef struct packed {
    dp_cmd_e cmd;
    status_e st;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic pos_root;
    logic kid_none;
    logic up_less;
    logic down_less;
  } sts_t;

endpackage

>>> design/bmhq_datapath.sv
// ---------------------------------------------------------------------------
// bmhq_datapath
// Heap store, sift position, moving entry, fill count and result registers.
// ---------------------------------------------------------------------------
`include "binary_min_heap_queue_core_defines.svh"

module bmhq_datapath #(
  parameter int CAPACITY = bmhq_pkg::DEFAULT_CAPACITY
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic signed [bmhq_pkg::VALUE_W-1:0]  value_i,
  input  bmhq_pkg::cmd_t                       cmd_i,
  output bmhq_pkg::sts_t                       sts_o,
  output logic signed [bmhq_pkg::VALUE_W-1:0]  min_value_o,
  output logic                                 is_empty_o,
  output logic [bmhq_pkg::COUNT_W-1:0]         entry_count_o,
  output logic [bmhq_pkg::STATUS_W-1:0]        status_o
);
  import bmhq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int KW = AW + 2;

  logic signed [VALUE_W-1:0] mem [CAPACITY];

  logic [CW-1:0]             fill_q;
  logic [AW-1:0]             pos_q;
  logic signed [VALUE_W-1:0] mov_q;
  logic signed [VALUE_W-1:0] root_q;
  logic signed [VALUE_W-1:0] rd_a_q;
  logic signed [VALUE_W-1:0] rd_b_q;

  logic signed [VALUE_W-1:0] min_q;
  logic                      empty_q;
  logic [COUNT_W-1:0]        count_q;
  logic [STATUS_W-1:0]       status_q;

  logic [AW-1:0]             parent_idx;
  logic [KW-1:0]             kid_l;
  logic [KW-1:0]             kid_r;
  logic                      r_ok;
  logic [KW-1:0]             pick_idx;
  logic signed [VALUE_W-1:0] pick_val;
  logic                      up_less;
  logic                      down_less;

  logic                      rd_en;
  logic [AW-1:0]             rd_addr;
  logic                      wr_en;
  logic [AW-1:0]             wr_addr;
  logic signed [VALUE_W-1:0] wr_data;

  assign parent_idx = (pos_q - AW'(1)) >> 1;
  assign kid_l      = KW'({pos_q, 1'b1});
  assign kid_r      = kid_l + KW'(1);
  assign r_ok       = kid_r < KW'(fill_q);
  assign pick_idx   = (r_ok && !(rd_a_q < rd_b_q)) ? kid_r : kid_l;
  assign pick_val   = (r_ok && !(rd_a_q < rd_b_q)) ? rd_b_q : rd_a_q;
  assign up_less    = mov_q < rd_a_q;
  assign down_less  = pick_val < mov_q;

  assign sts_o.full      = fill_q == CW'(CAPACITY);
  assign sts_o.empty     = fill_q == '0;
  assign sts_o.pos_root  = pos_q == '0;
  assign sts_o.kid_none  = kid_l >= KW'(fill_q);
  assign sts_o.up_less   = up_less;
  assign sts_o.down_less = down_less;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = AW'(kid_l);
    wr_en   = 1'b0;
    wr_addr = pos_q;
    wr_data = mov_q;
    unique case (cmd_i.cmd)
      DP_RD_PARENT: begin
        rd_en   = 1'b1;
        rd_addr = parent_idx;
      end
      DP_RD_LAST: begin
        rd_en   = 1'b1;
        rd_addr = AW'(fill_q);
      end
      DP_RD_KIDS: begin
        rd_en   = 1'b1;
      end
      DP_UP_STEP: begin
        wr_en   = 1'b1;
        wr_data = up_less ? rd_a_q : mov_q;
      end
      DP_DOWN_STEP: begin
        wr_en   = 1'b1;
        wr_data = down_less ? pick_val : mov_q;
      end
      DP_WR_MOV: begin
        wr_en   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a_q <= mem[rd_addr];
      rd_b_q <= mem[AW'(kid_r)];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (cmd_i.cmd == DP_PUSH_INIT) begin
      fill_q <= fill_q + CW'(1);
    end else if (cmd_i.cmd == DP_POP_INIT) begin
      fill_q <= fill_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en && wr_addr == '0) begin
      root_q <= wr_data;
    end
    unique case (cmd_i.cmd)
      DP_PUSH_INIT: begin
        pos_q <= AW'(fill_q);
        mov_q <= value_i;
      end
      DP_POP_INIT: begin
        pos_q <= '0;
      end
      DP_LOAD_MOV: begin
        mov_q <= rd_a_q;
      end
      DP_UP_STEP: begin
        if (up_less) begin
          pos_q <= parent_idx;
        end
      end
      DP_DOWN_STEP: begin
        if (down_less) begin
          pos_q <= AW'(pick_idx);
        end
      end
      DP_REPORT: begin
        min_q    <= (fill_q == '0) ? '0 : root_q;
        empty_q  <= fill_q == '0;
        count_q  <= COUNT_W'(fill_q);
        status_q <= cmd_i.st;
      end
      default: begin
      end
    endcase
  end

  assign min_value_o   = min_q;
  assign is_empty_o    = empty_q;
  assign entry_count_o = count_q;
  assign status_o      = status_q;

  `BMHQ_ASSERT(a_fill_bound, fill_q <= CW'(CAPACITY), "fill count above capacity")
  `BMHQ_ASSERT_IMP(a_wr_in_fill, wr_en, CW'(pos_q) < fill_q, "write beyond last entry")
  `BMHQ_ASSERT_IMP(a_fill_step, fill_q != $past(fill_q),
    (fill_q == $past(fill_q) + CW'(1)) || (fill_q == $past(fill_q) - CW'(1)),
    "fill count jumped")

endmodule

>>> design/bmhq_ctrl.sv
// ---------------------------------------------------------------------------
// bmhq_ctrl
// Sequencer for push sift-up, pop sift-down and result handoff.
// ---------------------------------------------------------------------------
`include "binary_min_heap_queue_core_defines.svh"

module bmhq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           op_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  bmhq_pkg::sts_t sts_i,
  output bmhq_pkg::cmd_t cmd_o
);
  import bmhq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_CHECK,
    S_UP_EVAL,
    S_POP_RD,
    S_POP_LOAD,
    S_DOWN_CHECK,
    S_DOWN_EVAL,
    S_REPORT
  } state_e;

  state_e  state_q, state_d;
  status_e st_q, st_d;
  logic    out_valid_q, out_valid_d;
  logic    accept;

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    st_d        = st_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '{cmd: DP_NOP, st: st_q};
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          st_d    = ST_OK;
          state_d = S_REPORT;
          if (op_i == OP_PUSH) begin
            if (sts_i.full) begin
              st_d = ST_FULL;
            end else begin
              cmd_o.cmd = DP_PUSH_INIT;
              state_d   = S_UP_CHECK;
            end
          end else begin
            if (sts_i.empty) begin
              st_d = ST_EMPTY;
            end else begin
              cmd_o.cmd = DP_POP_INIT;
              state_d   = S_POP_RD;
            end
          end
        end
      end
      S_UP_CHECK: begin
        if (sts_i.pos_root) begin
          cmd_o.cmd = DP_WR_MOV;
          state_d   = S_REPORT;
        end else begin
          cmd_o.cmd = DP_RD_PARENT;
          state_d   = S_UP_EVAL;
        end
      end
      S_UP_EVAL: begin
        cmd_o.cmd = DP_UP_STEP;
        state_d   = sts_i.up_less ? S_UP_CHECK : S_REPORT;
      end
      S_POP_RD: begin
        if (sts_i.empty) begin
          state_d = S_REPORT;
        end else begin
          cmd_o.cmd = DP_RD_LAST;
          state_d   = S_POP_LOAD;
        end
      end
      S_POP_LOAD: begin
        cmd_o.cmd = DP_LOAD_MOV;
        state_d   = S_DOWN_CHECK;
      end
      S_DOWN_CHECK: begin
        if (sts_i.kid_none) begin
          cmd_o.cmd = DP_WR_MOV;
          state_d   = S_REPORT;
        end else begin
          cmd_o.cmd = DP_RD_KIDS;
          state_d   = S_DOWN_EVAL;
        end
      end
      S_DOWN_EVAL: begin
        cmd_o.cmd = DP_DOWN_STEP;
        state_d   = sts_i.down_less ? S_DOWN_CHECK : S_REPORT;
      end
      S_REPORT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.cmd   = DP_REPORT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      st_q        <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
    end
  end

  `BMHQ_ASSERT_NEXT(a_pop_empty, accept && op_i == OP_POP && sts_i.empty,
    state_q == S_REPORT && st_q == ST_EMPTY, "pop on empty not reported")
  `BMHQ_ASSERT_NEXT(a_push_full, accept && op_i == OP_PUSH && sts_i.full,
    state_q == S_REPORT && st_q == ST_FULL, "push when full not reported")
  `BMHQ_ASSERT_NEXT(a_report, cmd_o.cmd == DP_REPORT,
    out_valid_q && state_q == S_IDLE, "result not presented after report")

endmodule

>>> design/binary_min_heap_queue_core.sv
// Binary min-heap priority queue of signed 32-bit values. Each request is a push
// or a pop; each yields exactly one result with the new minimum (0 when empty),
// an empty flag, the entry count and a status (ok, push dropped when full, pop
// on empty). Requests are handled one at a time. A push lets the value climb
// from the new last slot towards the root; a pop moves the last entry to the
// root and lets it sink towards a leaf, unless the heap is then empty. A
// dropped push or an empty pop goes straight to the result. Each level costs
// one registered read of the heap store followed by one compare and write. A
// new request is taken while the previous result still waits at the output
// register.
// ---------------------------------------------------------------------------
// binary_min_heap_queue_core
// Top level: sequencer plus heap datapath.
// ---------------------------------------------------------------------------
module binary_min_heap_queue_core #(
  parameter int CAPACITY = bmhq_pkg::DEFAULT_CAPACITY
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 op_i,
  input  logic signed [bmhq_pkg::VALUE_W-1:0]  value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [bmhq_pkg::VALUE_W-1:0]  min_value_o,
  output logic                                 is_empty_o,
  output logic [bmhq_pkg::COUNT_W-1:0]         entry_count_o,
  output logic [bmhq_pkg::STATUS_W-1:0]        status_o
);
  import bmhq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bmhq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bmhq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .value_i       (value_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .min_value_o   (min_value_o),
    .is_empty_o    (is_empty_o),
    .entry_count_o (entry_count_o),
    .status_o      (status_o)
  );

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Randomized self-checking bench for the binary min-heap queue. A local heap
// predicts minimum, empty flag, count and status for every accepted request;
// results are compared in order, with random idling on both channels.
// ---------------------------------------------------------------------------
module tb_top;
  import bmhq_pkg::*;

  localparam int HEAP_DEPTH   = DEFAULT_CAPACITY;
  localparam int RANDOM_ITEMS = 1000;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int TAIL_CYCLES  = 40;

  typedef struct {
    logic                op;
    logic [VALUE_W-1:0]  value;
    bit                  wait_drain;
  } heap_request_t;

  typedef struct {
    logic [VALUE_W-1:0]  min_value;
    logic                is_empty;
    logic [COUNT_W-1:0]  entry_count;
    status_e             status;
  } heap_result_t;

  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       in_valid_i  = 1'b0;
  logic                       op_i        = OP_PUSH;
  logic signed [VALUE_W-1:0]  value_i     = '0;
  logic                       out_ready_i = 1'b0;
  logic                       in_ready_o;
  logic                       out_valid_o;
  logic signed [VALUE_W-1:0]  min_value_o;
  logic                       is_empty_o;
  logic [COUNT_W-1:0]         entry_count_o;
  logic [STATUS_W-1:0]        status_o;

  heap_request_t  pending_q[$];
  heap_result_t   expected_q[$];
  int             sent_cnt  = 0;
  int             rcvd_cnt  = 0;
  int             fail_cnt  = 0;
  int             cycle_cnt = 0;

  logic signed [VALUE_W-1:0]  heap_mem [HEAP_DEPTH];
  int                         heap_fill = 0;

  binary_min_heap_queue_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .min_value_o   (min_value_o),
    .is_empty_o    (is_empty_o),
    .entry_count_o (entry_count_o),
    .status_o      (status_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic heap_result_t apply_request(logic op, logic [VALUE_W-1:0] value);
    heap_result_t                res;
    logic signed [VALUE_W-1:0]   tmp;
    int                          pos;
    int                          up;
    int                          lft;
    int                          pick;
    res.status = ST_OK;
    if (op == OP_PUSH) begin
      if (heap_fill >= HEAP_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        heap_mem[heap_fill] = value;
        pos = heap_fill;
        heap_fill++;
        while (pos > 0) begin
          up = (pos - 1) / 2;
          if (!(heap_mem[pos] < heap_mem[up])) break;
          tmp           = heap_mem[pos];
          heap_mem[pos] = heap_mem[up];
          heap_mem[up]  = tmp;
          pos           = up;
        end
      end
    end else begin
      if (heap_fill == 0) begin
        res.status = ST_EMPTY;
      end else begin
        heap_fill--;
        heap_mem[0] = heap_mem[heap_fill];
        pos = 0;
        while (heap_fill > 1) begin
          lft = 2 * pos + 1;
          if (lft >= heap_fill) break;
          if (lft + 1 < heap_fill)
            pick = (heap_mem[lft] < heap_mem[lft + 1]) ? lft : lft + 1;
          else
            pick = lft;
          if (!(heap_mem[pick] < heap_mem[pos])) break;
          tmp            = heap_mem[pos];
          heap_mem[pos]  = heap_mem[pick];
          heap_mem[pick] = tmp;
          pos            = pick;
        end
      end
    end
    res.min_value   = (heap_fill > 0) ? heap_mem[0] : '0;
    res.is_empty    = (heap_fill == 0);
    res.entry_count = heap_fill[COUNT_W-1:0];
    return res;
  endfunction

  function automatic logic [VALUE_W-1:0] draw_value();
    int unsigned pick;
    pick = $urandom_range(0, 15);
    if (pick < 2) begin
      case ($urandom_range(0, 3))
        0:       return 32'h7FFF_FFFF;
        1:       return 32'h8000_0000;
        2:       return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end else if (pick < 8) begin
      return $unsigned(32'(int'($urandom_range(0, 8)) - 4));
    end
    return $urandom;
  endfunction

  task automatic queue_request(logic op, logic [VALUE_W-1:0] value, bit wait_drain);
    heap_request_t req;
    req.op         = op;
    req.value      = value;
    req.wait_drain = wait_drain;
    pending_q.insert(pending_q.size(), req);
  endtask

  // driver
  bit            tx_paced = 1'b1;
  bit            tx_busy;
  int            tx_gap   = 0;
  int            tx_sent;
  heap_request_t tx_item;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      op_i       <= OP_PUSH;
      value_i    <= '0;
      sent_cnt   <= 0;
      tx_gap     = 0;
    end else begin
      tx_sent = sent_cnt;
      tx_busy = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        expected_q.insert(expected_q.size(), apply_request(op_i, value_i));
        tx_sent++;
        tx_busy = 1'b0;
        tx_gap  = tx_paced ? $urandom_range(0, 6) : 0;
        if ($urandom_range(0, 39) == 0) tx_paced = !tx_paced;
      end
      sent_cnt <= tx_sent;
      if (!tx_busy) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_q.size() > 0 &&
                     !(pending_q[0].wait_drain && tx_sent != rcvd_cnt)) begin
          tx_item    = pending_q.pop_front();
          in_valid_i <= 1'b1;
          op_i       <= tx_item.op;
          value_i    <= tx_item.value;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  bit           rx_paced = 1'b1;
  int           rx_stall = 0;
  heap_result_t rx_want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rcvd_cnt    <= 0;
      rx_stall    = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("result with no pending request: min_value %0d status %0d",
                 min_value_o, status_o);
          fail_cnt++;
        end else begin
          rx_want = expected_q.pop_front();
          if (min_value_o !== rx_want.min_value) begin
            $error("min_value expected %0d actual %0d",
                   $signed(rx_want.min_value), min_value_o);
            fail_cnt++;
          end
          if (is_empty_o !== rx_want.is_empty) begin
            $error("is_empty expected %0d actual %0d", rx_want.is_empty, is_empty_o);
            fail_cnt++;
          end
          if (entry_count_o !== rx_want.entry_count) begin
            $error("entry_count expected %0d actual %0d",
                   rx_want.entry_count, entry_count_o);
            fail_cnt++;
          end
          if (status_o !== rx_want.status) begin
            $error("status expected %s actual %0d", rx_want.status.name(), status_o);
            fail_cnt++;
          end
        end
        rcvd_cnt <= rcvd_cnt + 1;
        rx_stall = rx_paced ? $urandom_range(0, 6) : 0;
        if ($urandom_range(0, 39) == 0) rx_paced = !rx_paced;
      end
      if (rx_stall > 0) begin
        rx_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int unsigned push_pct;
    int          seg_len;
    int          seg_idx;
    int          total;

    queue_request(OP_POP,  '0, 1'b0);
    queue_request(OP_PUSH, 32'h7FFF_FFFF, 1'b0);
    queue_request(OP_PUSH, 32'h8000_0000, 1'b0);
    queue_request(OP_PUSH, 32'h0000_0000, 1'b0);
    queue_request(OP_PUSH, 32'hFFFF_FFFF, 1'b0);
    queue_request(OP_PUSH, 32'h0000_0001, 1'b0);
    queue_request(OP_PUSH, 32'h0000_0005, 1'b0);
    queue_request(OP_PUSH, 32'h0000_0005, 1'b0);
    queue_request(OP_PUSH, 32'h0000_0005, 1'b0);
    queue_request(OP_PUSH, 32'hFFFF_FFF9, 1'b0);
    repeat (10) queue_request(OP_POP, 32'hFFFF_FFFF, 1'b0);

    // alternate fill, drain and mixed phases so the heap hits full and empty
    total   = pending_q.size() + RANDOM_ITEMS;
    seg_idx = 0;
    while (pending_q.size() < total) begin
      case (seg_idx % 3)
        0:       push_pct = 90;
        1:       push_pct = 10;
        default: push_pct = 50;
      endcase
      seg_len = $urandom_range(60, 120);
      repeat (seg_len) begin
        queue_request(($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP, draw_value(),
                      (seg_idx == 0 && seg_len > 0 && pending_q.size() == 20) ||
                      $urandom_range(0, 99) == 0);
      end
      seg_idx++;
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_q.size() == 0 && !in_valid_i && sent_cnt == rcvd_cnt);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (expected_q.size() != 0) begin
      $error("%0d expected results never arrived", expected_q.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
